// ----- hw/rtl/wpa_pkg.sv -----
// Shared types, widths and weight tables for the weighted power average block.
// No dependencies; imported by wpa_ctrl, wpa_dp and weighted_power_average_core.
package wpa_pkg;

    localparam int SMP_W     = 31;            // stored sample width (positive only)
    localparam int W_W       = 15;            // tap weight width
    localparam int PROD_W    = SMP_W + W_W;   // one product
    localparam int NUM_W     = 48;            // weighted sum, < 2^31 * 117563
    localparam int DEN_W     = 17;            // weight sum, <= 117563
    localparam int WIDX_W    = 4;             // weight table index
    localparam int DIV_STEPS = NUM_W / 2;     // two quotient bits per cycle
    localparam int DIV_W     = $clog2(DIV_STEPS);

    localparam logic [1:0] MODE_CHG  = 2'd0;
    localparam logic [1:0] MODE_DIS  = 2'd1;
    localparam logic [1:0] MODE_NONE = 2'd2;

    typedef struct packed {
        logic load;       // take input word, update history
        logic mac_step;   // one multiply-accumulate step
        logic div_init;   // final accumulate, latch divisor
        logic div_step;   // two restoring division steps
        logic load_out;   // write result into output register
    } wpa_cmd_t;

    typedef struct packed {
        logic in_bad;     // current input sample is zero or negative
        logic mac_last;   // last stored sample being multiplied
        logic div_last;   // last division step
        logic out_free;   // output register can take a word
    } wpa_sts_t;

    // Weight of a tap, indexed from the oldest sample, scaled by 1000.
    function automatic logic [W_W-1:0] tap_weight(input logic [WIDX_W-1:0] idx);
        logic [W_W-1:0] w;
        begin
            case (idx)
                4'd0:    w = 15'd1000;
                4'd1:    w = 15'd2297;
                4'd2:    w = 15'd3737;
                4'd3:    w = 15'd5278;
                4'd4:    w = 15'd6899;
                4'd5:    w = 15'd8586;
                4'd6:    w = 15'd10330;
                4'd7:    w = 15'd12126;
                4'd8:    w = 15'd13967;
                4'd9:    w = 15'd15849;
                4'd10:   w = 15'd17769;
                4'd11:   w = 15'd19725;
                default: w = '0;
            endcase
            return w;
        end
    endfunction

    // Sum of the first cnt weights.
    function automatic logic [DEN_W-1:0] den_sum(input logic [WIDX_W-1:0] cnt);
        logic [DEN_W-1:0] s;
        begin
            case (cnt)
                4'd1:    s = 17'd1000;
                4'd2:    s = 17'd3297;
                4'd3:    s = 17'd7034;
                4'd4:    s = 17'd12312;
                4'd5:    s = 17'd19211;
                4'd6:    s = 17'd27797;
                4'd7:    s = 17'd38127;
                4'd8:    s = 17'd50253;
                4'd9:    s = 17'd64220;
                4'd10:   s = 17'd80069;
                4'd11:   s = 17'd97838;
                4'd12:   s = 17'd117563;
                default: s = '0;
            endcase
            return s;
        end
    endfunction

endpackage

// ----- hw/rtl/wpa_ctrl.sv -----
// Sequencer for the weighted power average: accept, MAC, divide, output.
// Depends on wpa_pkg for the command and status structs.
module wpa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  wpa_pkg::wpa_sts_t sts,
    output wpa_pkg::wpa_cmd_t cmd
);
    import wpa_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAC  = 3'd1;
    localparam logic [2:0] ST_FIN  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_RES  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.in_bad ? ST_RES : ST_MAC;
                end
            end
            ST_MAC:
            begin
                cmd.mac_step = 1'b1;
                if (sts.mac_last)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = ST_RES;
            end
            ST_RES:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- hw/rtl/wpa_dp.sv -----
// Datapath: sample history, serial MAC, radix-4 restoring divider, output register.
// Depends on wpa_pkg for widths, weight tables and command/status structs.
module wpa_dp #(
    parameter int HISTORY_DEPTH = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic signed [31:0] power_uw,
    input  logic               discharging,
    input  wpa_pkg::wpa_cmd_t  cmd,
    output wpa_pkg::wpa_sts_t  sts,
    output logic signed [31:0] avg_power_uw,
    output logic               out_valid,
    input  logic               out_stall
);
    import wpa_pkg::*;

    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(HISTORY_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(HISTORY_DEPTH - 1);

    logic [SMP_W-1:0]  hist_reg [HISTORY_DEPTH];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [1:0]        mode_reg;
    logic              bad_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic [NUM_W-1:0]  acc_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  div_cnt_reg;
    logic [31:0]       avg_reg;
    logic              out_valid_reg;

    logic              sample_ok;
    logic [1:0]        new_mode;
    logic [CNT_W-1:0]  base_cnt;
    logic              hist_full;
    logic [IDX_W-1:0]  wr_idx;

    logic [DEN_W:0]    r1;
    logic [DEN_W:0]    r2;
    logic              ge1;
    logic              ge2;
    logic [DEN_W-1:0]  r1s;
    logic [DEN_W-1:0]  r2s;

    // history bookkeeping for the incoming word
    assign sample_ok  = !power_uw[31] && (power_uw != '0);
    assign new_mode   = {1'b0, discharging};
    assign base_cnt   = (new_mode != mode_reg) ? '0 : count_reg;
    assign hist_full  = (base_cnt == DEPTH_CNT);
    assign wr_idx     = hist_full ? LAST_IDX : base_cnt[IDX_W-1:0];
    assign count_next = hist_full ? DEPTH_CNT : base_cnt + CNT_W'(1);

    assign prod_next = PROD_W'(hist_reg[idx_reg]) * PROD_W'(tap_weight(WIDX_W'(idx_reg)));

    // two restoring steps per cycle, quotient bits shift into acc_reg from the bottom
    assign r1  = {rem_reg, acc_reg[NUM_W-1]};
    assign ge1 = (r1 >= {1'b0, den_reg});
    assign r1s = ge1 ? DEN_W'(r1 - {1'b0, den_reg}) : r1[DEN_W-1:0];
    assign r2  = {r1s, acc_reg[NUM_W-2]};
    assign ge2 = (r2 >= {1'b0, den_reg});
    assign r2s = ge2 ? DEN_W'(r2 - {1'b0, den_reg}) : r2[DEN_W-1:0];

    assign sts.in_bad   = !sample_ok;
    assign sts.mac_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign sts.div_last = (div_cnt_reg == DIV_W'(DIV_STEPS - 1));
    assign sts.out_free = !out_valid_reg || !out_stall;

    assign avg_power_uw = avg_reg;
    assign out_valid    = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            mode_reg      <= MODE_NONE;
            bad_reg       <= 1'b0;
            idx_reg       <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                bad_reg <= !sample_ok;
                idx_reg <= '0;
                if (sample_ok)
                begin
                    count_reg <= count_next;
                    mode_reg  <= new_mode;
                end
                else
                    count_reg <= '0;
            end
            else if (cmd.mac_step)
                idx_reg <= idx_reg + IDX_W'(1);

            if (cmd.div_init)
                div_cnt_reg <= '0;
            else if (cmd.div_step)
                div_cnt_reg <= div_cnt_reg + DIV_W'(1);

            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && sample_ok)
        begin
            if (hist_full)
            begin
                for (int i = 0; i < HISTORY_DEPTH - 1; i++)
                    hist_reg[i] <= hist_reg[i + 1];
            end
            hist_reg[wr_idx] <= power_uw[SMP_W-1:0];
        end

        if (cmd.load)
        begin
            prod_reg <= '0;
            acc_reg  <= '0;
        end
        else if (cmd.mac_step)
        begin
            prod_reg <= prod_next;
            acc_reg  <= acc_reg + NUM_W'(prod_reg);
        end
        else if (cmd.div_init)
        begin
            acc_reg <= acc_reg + NUM_W'(prod_reg);
            den_reg <= den_sum(WIDX_W'(count_reg));
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            acc_reg <= {acc_reg[NUM_W-3:0], ge1, ge2};
            rem_reg <= r2s;
        end

        if (cmd.load_out)
            avg_reg <= bad_reg ? '1 : acc_reg[31:0];
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("history count above depth");

    a_div_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_init |-> (count_reg != '0))
        else $error("division started with empty history");

    a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && !bad_reg) |-> (acc_reg[NUM_W-1:31] == '0))
        else $error("quotient exceeds 31 bits");

endmodule

// ----- hw/rtl/weighted_power_average_core.sv -----
// Top level of the weighted power average: controller plus datapath.
// Depends on wpa_pkg, wpa_ctrl and wpa_dp.
//
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------
//  input   | in_valid / in_stall | power_uw[31:0] s, discharging
//  output  | out_valid/out_stall | avg_power_uw[31:0] s
//
// A valid sample runs a serial MAC of one tap per cycle over the n stored samples
// (at most HISTORY_DEPTH), a final accumulate, then a 48-bit restoring divider
// retiring two quotient bits per cycle; a zero or negative sample skips both.
// Reset clears the history count and the mode; history contents are not cleared.
// in_stall is high while a word is in work; a new word is taken while the
// previous result still waits in the output register.
module weighted_power_average_core #(
    parameter int HISTORY_DEPTH = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] power_uw,
    input  logic               discharging,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] avg_power_uw
);
    import wpa_pkg::*;

    wpa_cmd_t cmd;
    wpa_sts_t sts;

    wpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    wpa_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .power_uw     (power_uw),
        .discharging  (discharging),
        .cmd          (cmd),
        .sts          (sts),
        .avg_power_uw (avg_power_uw),
        .out_valid    (out_valid),
        .out_stall    (out_stall)
    );

endmodule

// ----- bench/tb_weighted_power_average_core.sv -----
`timescale 1ns / 100ps
// Self-checking bench for weighted_power_average_core: directed table, then random words.
// Depends on wpa_pkg and the core RTL; predicts each average in-line and checks in order.
module tb_weighted_power_average_core;
    import wpa_pkg::*;

    localparam int DEPTH       = 12;
    localparam int N_DIR       = 23;
    localparam int N_RAND      = 1200;
    localparam int N_CALM      = 200;     // closing words with no idling on either side
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN       = 64;
    localparam int LIMIT       = 400000;

    localparam logic signed [31:0] MAXP = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MINN = 32'sh8000_0000;
    localparam logic signed [31:0] NO_AVG = -32'sd1;

    typedef struct packed {
        logic signed [31:0] pwr;
        logic               dis;
        logic               fixed;   // want is typed in, else predicted
        logic signed [31:0] want;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] power_uw;
    logic               discharging;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] avg_power_uw;

    // predictor state
    logic [30:0] hist_smp [DEPTH];
    int          hist_cnt;
    logic [1:0]  prev_mode;
    int          tap_w [12] = '{1000, 2297, 3737, 5278, 6899, 8586,
                                10330, 12126, 13967, 15849, 17769, 19725};

    logic signed [31:0] avg_due_q [$];
    row_t               dir_rows [N_DIR];
    logic               cur_fixed;
    logic signed [31:0] cur_want;
    bit                 idle_on;
    bit                 hold_req;
    int                 n_err;
    int                 n_cyc;

    weighted_power_average_core #(.HISTORY_DEPTH(DEPTH)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .power_uw     (power_uw),
        .discharging  (discharging),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .avg_power_uw (avg_power_uw)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Updates the sample history with one word and returns the new weighted average.
    function automatic logic signed [31:0] weighted_avg_update(input logic signed [31:0] p,
                                                               input logic d);
        logic [47:0] acc;
        logic [47:0] q;
        logic [16:0] wsum;
        logic [1:0]  m;
        int          i;
        acc  = '0;
        wsum = '0;
        m    = d ? MODE_DIS : MODE_CHG;
        if (p <= 0)
        begin
            hist_cnt = 0;           // mode is kept
            return NO_AVG;
        end
        if (m != prev_mode)
        begin
            hist_cnt  = 0;
            prev_mode = m;
        end
        if (hist_cnt == DEPTH)
        begin
            for (i = 1; i < DEPTH; i++)
                hist_smp[i-1] = hist_smp[i];
            hist_cnt = DEPTH - 1;
        end
        hist_smp[hist_cnt] = p[30:0];
        hist_cnt++;
        for (i = 0; i < hist_cnt; i++)
        begin
            acc  = acc + 48'(hist_smp[i]) * 48'(tap_w[i]);
            wsum = wsum + 17'(tap_w[i]);
        end
        q = acc / {31'b0, wsum};
        return $signed(q[31:0]);
    endfunction

    // Offer one word from the current falling edge until it is taken.
    task automatic put_word(input logic signed [31:0] p, input logic d,
                            input logic fixed, input logic signed [31:0] want);
        power_uw    = p;
        discharging = d;
        cur_fixed   = fixed;
        cur_want    = want;
        in_valid    = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin : take_in
        logic signed [31:0] pred;
        if (rst_n && in_valid && !in_stall)
        begin
            pred = weighted_avg_update(power_uw, discharging);
            avg_due_q.push_back(cur_fixed ? cur_want : pred);
        end
    end

    always @(posedge clk)
    begin : chk_out
        logic signed [31:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (avg_due_q.size() == 0)
            begin
                n_err++;
                if (n_err <= 10)
                    $display("unexpected word: avg_power_uw=%0d", avg_power_uw);
            end
            else
            begin
                want = avg_due_q.pop_front();
                if (avg_power_uw !== want)
                begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch avg_power_uw: expected %0d, got %0d",
                                 want, avg_power_uw);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        n_cyc++;
        if (n_cyc > LIMIT)
        begin
            $display("timeout after %0d cycles", n_cyc);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: short random stall bursts, plus one long hold on request.
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall = 1'b0;
                hold_req  = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 13)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    initial
    begin
        int                 k;
        int                 seg_left;
        int                 sel;
        logic               seg_mode;
        logic signed [31:0] p;
        logic               d;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        power_uw    = '0;
        discharging = 1'b0;
        cur_fixed   = 1'b0;
        cur_want    = '0;
        idle_on     = 1'b0;
        hold_req    = 1'b0;
        n_err       = 0;
        n_cyc       = 0;
        hist_cnt    = 0;
        prev_mode   = MODE_NONE;
        for (k = 0; k < DEPTH; k++)
            hist_smp[k] = '0;

        // invalid words right after reset, full-scale fill past the depth,
        // mode changes, and an invalid word that must not touch the mode
        dir_rows[0]  = '{32'sd0,  1'b0, 1'b1, NO_AVG};
        dir_rows[1]  = '{MINN,    1'b1, 1'b1, NO_AVG};
        dir_rows[2]  = '{-32'sd1, 1'b0, 1'b1, NO_AVG};
        for (k = 3; k < 16; k++)
            dir_rows[k] = '{MAXP, 1'b1, 1'b1, MAXP};
        dir_rows[16] = '{32'sd1,  1'b0, 1'b1, 32'sd1};
        dir_rows[17] = '{32'sd1,  1'b0, 1'b1, 32'sd1};
        dir_rows[18] = '{32'sd2,  1'b0, 1'b0, 32'sd0};
        dir_rows[19] = '{-32'sd5, 1'b1, 1'b1, NO_AVG};
        dir_rows[20] = '{32'sd5,  1'b0, 1'b1, 32'sd5};
        dir_rows[21] = '{32'sd7,  1'b1, 1'b1, 32'sd7};
        dir_rows[22] = '{32'sh4000_0000, 1'b1, 1'b0, 32'sd0};

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (k = 0; k < N_DIR; k++)
            put_word(dir_rows[k].pwr, dir_rows[k].dis, dir_rows[k].fixed, dir_rows[k].want);

        // Random part: runs of valid samples in one mode, so the history fills
        // and rolls over, with some invalid and noise words mixed in.
        seg_left = 0;
        seg_mode = 1'b1;
        for (k = 0; k < N_RAND; k++)
        begin
            idle_on = (k < N_RAND - N_CALM) && ((k / 150) % 3 != 2);
            if (k == 300)
                hold_req = 1'b1;
            if (k == 700)
            begin
                in_valid = 1'b0;
                while (avg_due_q.size() != 0)
                    @(negedge clk);
            end
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                in_valid = 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
            end
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(1, 30);
                if ($urandom_range(0, 2) == 0)
                    seg_mode = ~seg_mode;
            end
            seg_left--;
            d   = seg_mode;
            sel = $urandom_range(0, 19);
            if (sel == 0)
                p = $urandom | 32'h8000_0000;
            else if (sel == 1)
                p = '0;
            else if (sel == 2)
            begin
                p = $urandom;
                d = 1'($urandom_range(0, 1));
            end
            else if (sel <= 6)
                p = $urandom_range(1, 1000);
            else if (sel <= 10)
                p = $urandom_range(1, 32'h000F_FFFF);
            else if (sel <= 15)
            begin
                p     = $urandom;
                p[31] = 1'b0;
                if (p == 0)
                    p = 32'sd1;
            end
            else
                p = MAXP - $urandom_range(0, 4095);
            put_word(p, d, 1'b0, '0);
        end
        in_valid = 1'b0;

        while (avg_due_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (n_err == 0 && avg_due_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- weighted_power_average_core.f -----
hw/rtl/wpa_pkg.sv
hw/rtl/wpa_ctrl.sv
hw/rtl/wpa_dp.sv
hw/rtl/weighted_power_average_core.sv
bench/tb_weighted_power_average_core.sv
